[design/gdfs_pkg.sv]
// Shared types and constants for the graph depth-first path search block.
package gdfs_pkg;

	// Graph dimensions.
	localparam int MAX_VERTICES = 16;
	localparam int VTX_W        = 4;
	localparam int CNT_W        = 5;
	localparam int LABEL_W      = 8;
	localparam int EDGE_W       = 9;
	localparam int ADJ_DEPTH    = MAX_VERTICES * MAX_VERTICES;

	// Operation codes of an input word.
	typedef enum logic [1:0] {
		OP_ADD_VERTEX = 2'd0,
		OP_ADD_EDGE   = 2'd1,
		OP_SEARCH     = 2'd2,
		OP_UNUSED     = 2'd3
	} op_t;

	// Result word kinds.
	typedef enum logic {
		KIND_ACK   = 1'b0,
		KIND_VISIT = 1'b1
	} kind_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_DUPLICATE = 2'd2,
		STAT_BAD_INDEX = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_EREAD = 8'b0000_0010,
		ST_ECMP  = 8'b0000_0100,
		ST_EAPP  = 8'b0000_1000,
		ST_TOP   = 8'b0001_0000,
		ST_CHK   = 8'b0010_0000,
		ST_VISIT = 8'b0100_0000,
		ST_FLUSH = 8'b1000_0000
	} state_t;

endpackage

[design/graph_dfs_path_search.sv]
// Top level of the graph store with depth-first path search.
// Add vertex: the result is sent from the flush state once the output register can load.
// Add edge: one adjacency RAM read and one compare per stored successor of the source.
// Search: one adjacency RAM read per entry scanned; edge scans and walk steps share the
// single read port of the adjacency RAM.
// Reset clears counts, totals and control at once; no clearing pass is needed.
module graph_dfs_path_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  op,
	input  logic [gdfs_pkg::LABEL_W-1:0] label,
	input  logic [gdfs_pkg::VTX_W-1:0]  from_vertex,
	input  logic [gdfs_pkg::VTX_W-1:0]  to_vertex,
	input  logic [gdfs_pkg::VTX_W-1:0]  start_vertex,
	input  logic [gdfs_pkg::VTX_W-1:0]  target_vertex,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        kind,
	output logic [gdfs_pkg::VTX_W-1:0]  vertex_index,
	output logic [gdfs_pkg::LABEL_W-1:0] vertex_label,
	output logic                        found,
	output logic [1:0]                  status,
	output logic [gdfs_pkg::EDGE_W-1:0] edge_total,
	output logic                        last
);

	localparam int AW = $clog2(gdfs_pkg::ADJ_DEPTH);

	gdfs_pkg::state_t state_q;

	// Graph store.
	logic [gdfs_pkg::LABEL_W-1:0] labels_q [gdfs_pkg::MAX_VERTICES];
	logic [gdfs_pkg::CNT_W-1:0]   counts_q [gdfs_pkg::MAX_VERTICES];
	logic [gdfs_pkg::CNT_W-1:0]   vtx_total_q;
	logic [gdfs_pkg::EDGE_W-1:0]  edge_q;

	// Walk state.
	logic [gdfs_pkg::MAX_VERTICES-1:0] visited_q;
	logic [gdfs_pkg::VTX_W-1:0]        stack_v_q [gdfs_pkg::MAX_VERTICES];
	logic [gdfs_pkg::CNT_W-1:0]        stack_p_q [gdfs_pkg::MAX_VERTICES];
	logic [gdfs_pkg::CNT_W-1:0]        depth_q;
	logic                              hit_q;
	logic [gdfs_pkg::VTX_W-1:0]        target_q;
	logic [gdfs_pkg::VTX_W-1:0]        next_q;

	// Edge scan state.
	logic [gdfs_pkg::VTX_W-1:0] from_q;
	logic [gdfs_pkg::VTX_W-1:0] to_q;
	logic [gdfs_pkg::VTX_W-1:0] idx_q;

	// Pending result word, held until the next one or the end of the item is known.
	gdfs_pkg::kind_t              p_kind_q;
	logic [gdfs_pkg::VTX_W-1:0]   p_idx_q;
	logic [gdfs_pkg::LABEL_W-1:0] p_label_q;
	gdfs_pkg::status_t            p_status_q;

	// Output register.
	logic                         out_valid_q;
	gdfs_pkg::kind_t              o_kind_q;
	logic [gdfs_pkg::VTX_W-1:0]   o_idx_q;
	logic [gdfs_pkg::LABEL_W-1:0] o_label_q;
	logic                         o_found_q;
	gdfs_pkg::status_t            o_status_q;
	logic [gdfs_pkg::EDGE_W-1:0]  o_edge_q;
	logic                         o_last_q;

	// Adjacency RAM signals.
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [gdfs_pkg::VTX_W-1:0] ram_rdata;

	// Combinational views.
	logic                       accept;
	logic                       can_load;
	logic                       out_load;
	logic [gdfs_pkg::CNT_W-1:0] depth_m1;
	logic [gdfs_pkg::VTX_W-1:0] top_idx;
	logic [gdfs_pkg::VTX_W-1:0] top_v;
	logic [gdfs_pkg::CNT_W-1:0] top_p;
	logic [gdfs_pkg::CNT_W-1:0] top_cnt;
	logic                       top_more;
	logic [gdfs_pkg::CNT_W-1:0] from_cnt;
	logic [gdfs_pkg::CNT_W-1:0] idx_next;
	logic                       in_search_range;
	logic                       in_edge_range;

	assign in_stall = (state_q != gdfs_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign can_load = !out_valid_q || !out_stall;
	assign out_load = can_load
		&& ((state_q == gdfs_pkg::ST_VISIT) || (state_q == gdfs_pkg::ST_FLUSH));

	// Top-of-stack frame and the successor count of its vertex.
	assign depth_m1 = depth_q - gdfs_pkg::CNT_W'(1);
	assign top_idx  = depth_m1[gdfs_pkg::VTX_W-1:0];
	assign top_v    = stack_v_q[top_idx];
	assign top_p    = stack_p_q[top_idx];
	assign top_cnt  = counts_q[top_v];
	assign top_more = (depth_q != '0) && (top_p < top_cnt);

	assign from_cnt = counts_q[from_q];
	assign idx_next = {1'b0, idx_q} + gdfs_pkg::CNT_W'(1);

	assign in_search_range = ({1'b0, start_vertex} < vtx_total_q)
		&& ({1'b0, target_vertex} < vtx_total_q);
	assign in_edge_range = ({1'b0, from_vertex} < vtx_total_q)
		&& ({1'b0, to_vertex} < vtx_total_q);

	// Adjacency RAM port control: edge scans and walk steps share the read port.
	always_comb begin
		ram_we    = (state_q == gdfs_pkg::ST_EAPP)
			&& (from_cnt < gdfs_pkg::CNT_W'(gdfs_pkg::MAX_VERTICES));
		ram_waddr = {from_q, from_cnt[gdfs_pkg::VTX_W-1:0]};
		if (state_q == gdfs_pkg::ST_EREAD) begin
			ram_re    = 1'b1;
			ram_raddr = {from_q, idx_q};
		end else begin
			ram_re    = (state_q == gdfs_pkg::ST_TOP) && top_more;
			ram_raddr = {top_v, top_p[gdfs_pkg::VTX_W-1:0]};
		end
	end

	gdfs_ram #(
		.WIDTH(gdfs_pkg::VTX_W),
		.DEPTH(gdfs_pkg::ADJ_DEPTH)
	) u_adj_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (to_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Payload registers of the graph store and the walk stack.
	always_ff @(posedge clk) begin
		if (accept && (op == gdfs_pkg::OP_ADD_VERTEX)
				&& (vtx_total_q < gdfs_pkg::CNT_W'(gdfs_pkg::MAX_VERTICES))) begin
			labels_q[vtx_total_q[gdfs_pkg::VTX_W-1:0]] <= label;
		end
		if (accept && (op == gdfs_pkg::OP_SEARCH)) begin
			stack_v_q[0] <= start_vertex;
			stack_p_q[0] <= '0;
		end
		if ((state_q == gdfs_pkg::ST_TOP) && top_more) begin
			stack_p_q[top_idx] <= top_p + gdfs_pkg::CNT_W'(1);
		end
		if ((state_q == gdfs_pkg::ST_VISIT) && can_load && (next_q != target_q)
				&& (depth_q < gdfs_pkg::CNT_W'(gdfs_pkg::MAX_VERTICES))) begin
			stack_v_q[depth_q[gdfs_pkg::VTX_W-1:0]] <= next_q;
			stack_p_q[depth_q[gdfs_pkg::VTX_W-1:0]] <= '0;
		end
	end

	// Sequencer, counters and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gdfs_pkg::ST_IDLE;
			vtx_total_q <= '0;
			edge_q      <= '0;
			visited_q   <= '0;
			depth_q     <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < gdfs_pkg::MAX_VERTICES; i++) begin
				counts_q[i] <= '0;
			end
		end else begin
			// The output word is taken and no new word is loaded behind it.
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				gdfs_pkg::ST_IDLE: begin
					if (accept) begin
						hit_q    <= (op == gdfs_pkg::OP_SEARCH) && in_search_range
							&& (start_vertex == target_vertex);
						from_q   <= from_vertex;
						to_q     <= to_vertex;
						target_q <= target_vertex;
						idx_q    <= '0;
						case (op)
							gdfs_pkg::OP_ADD_VERTEX: begin
								p_kind_q  <= gdfs_pkg::KIND_ACK;
								p_label_q <= label;
								state_q   <= gdfs_pkg::ST_FLUSH;
								if (vtx_total_q < gdfs_pkg::CNT_W'(gdfs_pkg::MAX_VERTICES)) begin
									counts_q[vtx_total_q[gdfs_pkg::VTX_W-1:0]] <= '0;
									vtx_total_q <= vtx_total_q + gdfs_pkg::CNT_W'(1);
									p_idx_q     <= vtx_total_q[gdfs_pkg::VTX_W-1:0];
									p_status_q  <= gdfs_pkg::STAT_OK;
								end else begin
									p_idx_q    <= '0;
									p_status_q <= gdfs_pkg::STAT_FULL;
								end
							end
							gdfs_pkg::OP_ADD_EDGE: begin
								p_kind_q  <= gdfs_pkg::KIND_ACK;
								p_idx_q   <= from_vertex;
								p_label_q <= '0;
								if (!in_edge_range) begin
									p_status_q <= gdfs_pkg::STAT_BAD_INDEX;
									state_q    <= gdfs_pkg::ST_FLUSH;
								end else if (counts_q[from_vertex] == '0) begin
									state_q <= gdfs_pkg::ST_EAPP;
								end else begin
									state_q <= gdfs_pkg::ST_EREAD;
								end
							end
							gdfs_pkg::OP_SEARCH: begin
								p_kind_q <= gdfs_pkg::KIND_VISIT;
								p_idx_q  <= start_vertex;
								if (!in_search_range) begin
									p_label_q  <= '0;
									p_status_q <= gdfs_pkg::STAT_BAD_INDEX;
									state_q    <= gdfs_pkg::ST_FLUSH;
								end else begin
									p_label_q  <= labels_q[start_vertex];
									p_status_q <= gdfs_pkg::STAT_OK;
									visited_q  <= gdfs_pkg::MAX_VERTICES'(1) << start_vertex;
									depth_q    <= gdfs_pkg::CNT_W'(1);
									if (start_vertex == target_vertex) begin
										state_q <= gdfs_pkg::ST_FLUSH;
									end else begin
										state_q <= gdfs_pkg::ST_TOP;
									end
								end
							end
							default: begin
								state_q <= gdfs_pkg::ST_IDLE;
							end
						endcase
					end
				end

				// Read one stored successor of the edge source.
				gdfs_pkg::ST_EREAD: begin
					state_q <= gdfs_pkg::ST_ECMP;
				end

				// Compare it with the new destination.
				gdfs_pkg::ST_ECMP: begin
					if (ram_rdata == to_q) begin
						p_status_q <= gdfs_pkg::STAT_DUPLICATE;
						state_q    <= gdfs_pkg::ST_FLUSH;
					end else if (idx_next >= from_cnt) begin
						state_q <= gdfs_pkg::ST_EAPP;
					end else begin
						idx_q   <= idx_next[gdfs_pkg::VTX_W-1:0];
						state_q <= gdfs_pkg::ST_EREAD;
					end
				end

				// Append the edge; the RAM write happens in this cycle.
				gdfs_pkg::ST_EAPP: begin
					if (from_cnt < gdfs_pkg::CNT_W'(gdfs_pkg::MAX_VERTICES)) begin
						counts_q[from_q] <= from_cnt + gdfs_pkg::CNT_W'(1);
						edge_q           <= edge_q + gdfs_pkg::EDGE_W'(1);
					end
					p_status_q <= gdfs_pkg::STAT_OK;
					state_q    <= gdfs_pkg::ST_FLUSH;
				end

				// Fetch the next successor of the top frame, or pop it.
				gdfs_pkg::ST_TOP: begin
					if (depth_q == '0) begin
						state_q <= gdfs_pkg::ST_FLUSH;
					end else if (top_more) begin
						state_q <= gdfs_pkg::ST_CHK;
					end else begin
						depth_q <= depth_m1;
					end
				end

				// Skip a successor that was already visited.
				gdfs_pkg::ST_CHK: begin
					if (visited_q[ram_rdata]) begin
						state_q <= gdfs_pkg::ST_TOP;
					end else begin
						visited_q[ram_rdata] <= 1'b1;
						next_q               <= ram_rdata;
						state_q              <= gdfs_pkg::ST_VISIT;
					end
				end

				// Send the previous report and hold the new vertex as pending.
				gdfs_pkg::ST_VISIT: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						o_kind_q    <= p_kind_q;
						o_idx_q     <= p_idx_q;
						o_label_q   <= p_label_q;
						o_found_q   <= 1'b0;
						o_status_q  <= p_status_q;
						o_edge_q    <= edge_q;
						o_last_q    <= 1'b0;
						p_idx_q     <= next_q;
						p_label_q   <= labels_q[next_q];
						p_status_q  <= gdfs_pkg::STAT_OK;
						if (next_q == target_q) begin
							hit_q   <= 1'b1;
							state_q <= gdfs_pkg::ST_FLUSH;
						end else begin
							if (depth_q < gdfs_pkg::CNT_W'(gdfs_pkg::MAX_VERTICES)) begin
								depth_q <= depth_q + gdfs_pkg::CNT_W'(1);
							end
							state_q <= gdfs_pkg::ST_TOP;
						end
					end
				end

				// Send the pending word as the final result of the item.
				gdfs_pkg::ST_FLUSH: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						o_kind_q    <= p_kind_q;
						o_idx_q     <= p_idx_q;
						o_label_q   <= p_label_q;
						o_found_q   <= hit_q;
						o_status_q  <= p_status_q;
						o_edge_q    <= edge_q;
						o_last_q    <= 1'b1;
						state_q     <= gdfs_pkg::ST_IDLE;
					end
				end

				default: begin
					state_q <= gdfs_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = o_kind_q;
	assign vertex_index = o_idx_q;
	assign vertex_label = o_label_q;
	assign found        = o_found_q;
	assign status       = o_status_q;
	assign edge_total   = o_edge_q;
	assign last         = o_last_q;

	// The walk stack never holds more frames than the maximum vertex count.
	assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= gdfs_pkg::CNT_W'(gdfs_pkg::MAX_VERTICES))
		else $error("walk stack depth exceeds vertex count");

	// Found is only reported on the final word of an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> last)
		else $error("found set on a word that is not last");

	// The edge total only ever grows by one at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		edge_q != $past(edge_q) |-> edge_q == $past(edge_q) + gdfs_pkg::EDGE_W'(1))
		else $error("edge total changed by more than one");

	// A vertex about to be reported has been marked visited.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gdfs_pkg::ST_VISIT |-> visited_q[next_q])
		else $error("reported vertex is not marked visited");

endmodule

[design/gdfs_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module gdfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
